[hw/rtl/obc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obc_pkg
// shared constants, codes and control structs of the ordered broadcast channel
// ----------------------------------------------------------------------------
package obc_pkg;

    localparam int MAX_CONSUMERS = 8;
    localparam int MAX_MESSAGES  = 16;
    localparam int WORD_BITS     = 32;

    localparam int CONS_W     = $clog2(MAX_CONSUMERS);
    localparam int SLOT_W     = $clog2(MAX_MESSAGES);
    localparam int HELD_W     = $clog2(MAX_MESSAGES + 1);
    localparam int SEQ_W      = 32;
    localparam int LEN_W      = 8;
    localparam int USED_W     = 16;
    localparam int USED_SUM_W = USED_W + 1;
    localparam int COUNT_W    = 4;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SEQ_W-1:0]      SEQ_TOP        = '1;
    localparam logic [USED_W-1:0]     CAPACITY_RESET = 16'd4096;
    localparam logic [COUNT_W-1:0]    COUNT_RESET    = 4'd1;

    localparam logic [CFG_IDX_W-1:0]  CFG_CAPACITY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_CONSUMERS  = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUBLISH = 3'd0,
        FN_RESERVE = 3'd1,
        FN_COMMIT  = 3'd2,
        FN_CANCEL  = 3'd3,
        FN_CLOSE   = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BLOCK    = 3'd1,
        ST_CLOSED   = 3'd2,
        ST_INVALID  = 3'd3,
        ST_NOSPACE  = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef logic [SLOT_W-1:0]        t_slot;
    typedef logic [MAX_CONSUMERS-1:0] t_cmask;

    // requests from the sequencing logic to the message ring
    typedef struct packed {
        logic                 pub_we;
        t_slot                pub_slot;
        logic [WORD_BITS-1:0] pub_word;
        logic [LEN_W-1:0]     pub_len;
        t_slot                acc_slot;
        logic                 flag_we;
        t_cmask               acc_res;
        t_cmask               acc_com;
        logic                 rd_en;
        t_slot                head_slot;
        t_cmask               active_mask;
    } t_ring_ctrl;

    // what the ring reports back
    typedef struct packed {
        t_cmask                  acc_res;
        t_cmask                  acc_com;
        logic [MAX_MESSAGES-1:0] done;
        logic [LEN_W-1:0]        head_len;
    } t_ring_stat;

endpackage
`default_nettype wire

[hw/rtl/obc_ring.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obc_ring
// message slots: payload memory, head length memory and per-slot consumer flags
// ----------------------------------------------------------------------------
module obc_ring
    import obc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_ring_ctrl           i_ctrl,
    output t_ring_stat                o_stat,
    output logic [WORD_BITS-1:0]      o_rd_word,
    output logic [LEN_W-1:0]          o_rd_len
);

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [LEN_W-1:0]     len;
    } t_entry;

    t_entry           r_entry_mem [MAX_MESSAGES];
    logic [LEN_W-1:0] r_len_mem   [MAX_MESSAGES];
    t_cmask           r_res_flags [MAX_MESSAGES];
    t_cmask           r_com_flags [MAX_MESSAGES];
    t_entry           r_rd_entry;
    logic [LEN_W-1:0] r_head_len;

    // payload memory, read port feeds the result
    always_ff @(posedge i_clk) begin
        if (i_ctrl.pub_we) begin
            r_entry_mem[i_ctrl.pub_slot] <= '{word: i_ctrl.pub_word, len: i_ctrl.pub_len};
        end
        if (i_ctrl.rd_en) begin
            r_rd_entry <= r_entry_mem[i_ctrl.acc_slot];
        end
    end

    // length copy, read at the next oldest slot with write bypass
    always_ff @(posedge i_clk) begin
        if (i_ctrl.pub_we) begin
            r_len_mem[i_ctrl.pub_slot] <= i_ctrl.pub_len;
        end
        if (i_ctrl.pub_we && (i_ctrl.pub_slot == i_ctrl.head_slot)) begin
            r_head_len <= i_ctrl.pub_len;
        end else begin
            r_head_len <= r_len_mem[i_ctrl.head_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pub_we) begin
            r_res_flags[i_ctrl.pub_slot] <= '0;
            r_com_flags[i_ctrl.pub_slot] <= '0;
        end else if (i_ctrl.flag_we) begin
            r_res_flags[i_ctrl.acc_slot] <= i_ctrl.acc_res;
            r_com_flags[i_ctrl.acc_slot] <= i_ctrl.acc_com;
        end
    end

    always_comb begin
        o_stat.acc_res  = r_res_flags[i_ctrl.acc_slot];
        o_stat.acc_com  = r_com_flags[i_ctrl.acc_slot];
        o_stat.head_len = r_head_len;
        for (int s = 0; s < MAX_MESSAGES; s++) begin
            o_stat.done[s] = (r_com_flags[s] & i_ctrl.active_mask) == i_ctrl.active_mask;
        end
    end

    assign o_rd_word = r_rd_entry.word;
    assign o_rd_len  = r_rd_entry.len;

endmodule
`default_nettype wire

[hw/rtl/ordered_broadcast_channel_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_broadcast_channel_core
// sequenced broadcast queue: every active consumer reads every message in order
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                   | beat contents
//  ---------+-----+-----------------------------+-------------------------------------
//  in       | in  | i_in_valid / o_in_ready     | func, consumer, sequence_req,
//           |     |                             | payload_data, payload_bytes
//  out      | out | o_out_valid / i_out_ready   | status, result_sequence,
//           |     |                             | result_data, result_bytes
//  cfg      | in  | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
//  one operation per cycle unless the output stalls or a drain runs; a beat is
//  registered on accept, its result in the output register when it moves on
//  a commit that frees the oldest message while further fully committed ones
//  follow (only after consumer_count was lowered) starts a drain that frees
//  them one by one, during which the input side is held off
//  reset is synchronous and active low; slot contents need no clearing pass
//  a stalled output holds the next beat in the input register
// ----------------------------------------------------------------------------
module ordered_broadcast_channel_core
    import obc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // operation beats
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [CONS_W-1:0]     i_consumer,
    input  wire logic [SEQ_W-1:0]      i_sequence_req,
    input  wire logic [WORD_BITS-1:0]  i_payload_data,
    input  wire logic [LEN_W-1:0]      i_payload_bytes,
    // result beats
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic [SEQ_W-1:0]           o_result_sequence,
    output logic [WORD_BITS-1:0]       o_result_data,
    output logic [LEN_W-1:0]           o_result_bytes,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [USED_W-1:0]  r_capacity;
    logic [COUNT_W-1:0] r_cons_count;

    // input register
    logic                 r_in_valid;
    logic [FUNC_W-1:0]    r_in_func;
    logic [CONS_W-1:0]    r_in_consumer;
    logic [SEQ_W-1:0]     r_in_seq;
    logic [WORD_BITS-1:0] r_in_data;
    logic [LEN_W-1:0]     r_in_bytes;

    // channel state
    logic [SEQ_W-1:0]  r_send,   n_send;
    logic [SEQ_W-1:0]  r_oldest, n_oldest;
    logic [HELD_W-1:0] r_held,   n_held;
    logic [USED_W-1:0] r_used,   n_used;
    logic              r_closed, n_closed;
    logic              r_drain,  n_drain;
    logic [SEQ_W-1:0]  r_cursor [MAX_CONSUMERS];
    logic [SEQ_W-1:0]  n_cursor [MAX_CONSUMERS];
    logic              r_holds  [MAX_CONSUMERS];
    logic              n_holds  [MAX_CONSUMERS];
    logic [SEQ_W-1:0]  r_resat  [MAX_CONSUMERS];
    logic [SEQ_W-1:0]  n_resat  [MAX_CONSUMERS];

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SEQ_W-1:0]    r_out_seq;
    logic                r_out_rsv;

    // step logic
    logic                 w_adv;
    t_status              w_status;
    logic [SEQ_W-1:0]     w_rseq;
    logic                 w_rsv;
    logic [COUNT_W-1:0]   w_active;
    t_cmask               w_mask;
    t_cmask               w_cbit;
    logic                 w_cons_ok;
    logic [SEQ_W-1:0]     w_cur;
    logic                 w_cur_held;
    logic                 w_seq_held;
    logic [USED_SUM_W-1:0] w_used_sum;
    t_slot                w_oldest_slot;
    t_slot                w_next_slot;
    t_slot                w_acc_slot;
    t_cmask               w_new_res;
    t_cmask               w_new_com;
    logic                 w_head_done;
    logic                 w_next_done;

    t_ring_ctrl           w_ctrl;
    t_ring_stat           w_stat;
    logic [WORD_BITS-1:0] w_rd_word;
    logic [LEN_W-1:0]     w_rd_len;

    // a beat moves on once the result slot frees up and no drain is running
    assign w_adv      = r_in_valid && !r_drain && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // effective consumer count and its mask
    always_comb begin
        if (r_cons_count == '0) begin
            w_active = COUNT_W'(1);
        end else if (r_cons_count > COUNT_W'(MAX_CONSUMERS)) begin
            w_active = COUNT_W'(MAX_CONSUMERS);
        end else begin
            w_active = r_cons_count;
        end
        for (int i = 0; i < MAX_CONSUMERS; i++) begin
            w_mask[i] = COUNT_W'(i) < w_active;
        end
    end

    assign w_cons_ok     = COUNT_W'(r_in_consumer) < w_active;
    assign w_cbit        = t_cmask'(1) << r_in_consumer;
    assign w_cur         = r_cursor[r_in_consumer];
    // held means the offset from the oldest sequence is below the held count
    assign w_cur_held    = (w_cur - r_oldest) < SEQ_W'(r_held);
    assign w_seq_held    = (r_in_seq - r_oldest) < SEQ_W'(r_held);
    assign w_used_sum    = {1'b0, r_used} + USED_SUM_W'(r_in_bytes);
    assign w_oldest_slot = r_oldest[SLOT_W-1:0];
    assign w_next_slot   = w_oldest_slot + t_slot'(1);
    assign w_acc_slot    = (t_func'(r_in_func) == FN_RESERVE) ? w_cur[SLOT_W-1:0]
                                                               : r_in_seq[SLOT_W-1:0];

    always_comb begin
        n_send    = r_send;
        n_oldest  = r_oldest;
        n_held    = r_held;
        n_used    = r_used;
        n_closed  = r_closed;
        n_drain   = r_drain;
        n_cursor  = r_cursor;
        n_holds   = r_holds;
        n_resat   = r_resat;
        w_status  = ST_INVALID;
        w_rseq    = '0;
        w_rsv     = 1'b0;
        w_new_res = w_stat.acc_res;
        w_new_com = w_stat.acc_com;
        w_head_done = 1'b0;
        w_next_done = 1'b0;

        w_ctrl             = '0;
        w_ctrl.pub_slot    = r_send[SLOT_W-1:0];
        w_ctrl.pub_word    = r_in_data;
        w_ctrl.pub_len     = r_in_bytes;
        w_ctrl.acc_slot    = w_acc_slot;
        w_ctrl.rd_en       = w_adv;
        w_ctrl.active_mask = w_mask;

        if (r_drain) begin
            // free one more fully committed message per cycle
            if ((r_held != '0) && w_stat.done[w_oldest_slot]) begin
                n_oldest = r_oldest + SEQ_W'(1);
                n_held   = r_held - HELD_W'(1);
                n_used   = r_used - USED_W'(w_stat.head_len);
                n_drain  = (r_held > HELD_W'(1)) && w_stat.done[w_next_slot];
            end else begin
                n_drain  = 1'b0;
            end
        end else if (w_adv) begin
            case (t_func'(r_in_func))
                FN_PUBLISH: begin
                    if (r_closed) begin
                        w_status = ST_INVALID;
                    end else if (w_used_sum > {1'b0, r_capacity}) begin
                        w_status = ST_NOSPACE;
                    end else if (r_held >= HELD_W'(MAX_MESSAGES)) begin
                        w_status = ST_NOSPACE;
                    end else if (r_send == SEQ_TOP) begin
                        w_status = ST_OVERFLOW;
                    end else begin
                        w_ctrl.pub_we = 1'b1;
                        w_rseq   = r_send;
                        n_send   = r_send + SEQ_W'(1);
                        n_held   = r_held + HELD_W'(1);
                        n_used   = w_used_sum[USED_W-1:0];
                        w_status = ST_OK;
                    end
                end
                FN_RESERVE: begin
                    if (w_cons_ok && !r_holds[r_in_consumer]) begin
                        if (!w_cur_held) begin
                            w_rseq   = w_cur;
                            w_status = (r_closed && (w_cur >= r_send)) ? ST_CLOSED : ST_BLOCK;
                        end else if (((w_stat.acc_res | w_stat.acc_com) & w_cbit) == '0) begin
                            w_new_res      = w_stat.acc_res | w_cbit;
                            w_ctrl.flag_we = 1'b1;
                            n_holds[r_in_consumer] = 1'b1;
                            n_resat[r_in_consumer] = w_cur;
                            w_rseq   = w_cur;
                            w_rsv    = 1'b1;
                            w_status = ST_OK;
                        end
                    end
                end
                FN_COMMIT, FN_CANCEL: begin
                    if (w_cons_ok && r_holds[r_in_consumer]
                            && (r_resat[r_in_consumer] == r_in_seq) && w_seq_held
                            && ((w_stat.acc_res & w_cbit) != '0)
                            && ((w_stat.acc_com & w_cbit) == '0)
                            && ((t_func'(r_in_func) == FN_CANCEL)
                                || (r_cursor[r_in_consumer] == r_in_seq))) begin
                        w_new_res      = w_stat.acc_res & ~w_cbit;
                        w_ctrl.flag_we = 1'b1;
                        n_holds[r_in_consumer] = 1'b0;
                        w_status = ST_OK;
                        if (t_func'(r_in_func) == FN_COMMIT) begin
                            w_new_com = w_stat.acc_com | w_cbit;
                            if (r_in_seq == SEQ_TOP) begin
                                w_status = ST_OVERFLOW;
                            end else begin
                                n_cursor[r_in_consumer] = r_in_seq + SEQ_W'(1);
                                // slot done flags, with this commit folded in
                                w_head_done = (w_acc_slot == w_oldest_slot)
                                    ? ((w_new_com & w_mask) == w_mask)
                                    : w_stat.done[w_oldest_slot];
                                w_next_done = (w_acc_slot == w_next_slot)
                                    ? ((w_new_com & w_mask) == w_mask)
                                    : w_stat.done[w_next_slot];
                                if (w_head_done) begin
                                    n_oldest = r_oldest + SEQ_W'(1);
                                    n_held   = r_held - HELD_W'(1);
                                    n_used   = r_used - USED_W'(w_stat.head_len);
                                    n_drain  = (r_held > HELD_W'(1)) && w_next_done;
                                end
                            end
                        end
                    end
                end
                FN_CLOSE: begin
                    if (!r_closed) begin
                        n_closed = 1'b1;
                        w_status = ST_OK;
                    end
                end
                default: begin
                    w_status = ST_INVALID;
                end
            endcase
        end

        w_ctrl.acc_res   = w_new_res;
        w_ctrl.acc_com   = w_new_com;
        w_ctrl.head_slot = n_oldest[SLOT_W-1:0];
    end

    obc_ring u_ring (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .o_stat    (w_stat),
        .o_rd_word (w_rd_word),
        .o_rd_len  (w_rd_len)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAPACITY_RESET;
            r_cons_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAPACITY:  r_capacity   <= i_cfg_data[USED_W-1:0];
                CFG_CONSUMERS: r_cons_count <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_func     <= i_func;
            r_in_consumer <= i_consumer;
            r_in_seq      <= i_sequence_req;
            r_in_data     <= i_payload_data;
            r_in_bytes    <= i_payload_bytes;
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send   <= '0;
            r_oldest <= '0;
            r_held   <= '0;
            r_used   <= '0;
            r_closed <= 1'b0;
            r_drain  <= 1'b0;
            for (int i = 0; i < MAX_CONSUMERS; i++) begin
                r_cursor[i] <= '0;
                r_holds[i]  <= 1'b0;
            end
        end else begin
            r_send   <= n_send;
            r_oldest <= n_oldest;
            r_held   <= n_held;
            r_used   <= n_used;
            r_closed <= n_closed;
            r_drain  <= n_drain;
            r_cursor <= n_cursor;
            r_holds  <= n_holds;
        end
    end

    // reservation sequence is only read while the hold flag is set
    always_ff @(posedge i_clk) begin
        r_resat <= n_resat;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status <= w_status;
            r_out_seq    <= w_rseq;
            r_out_rsv    <= w_rsv;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_result_sequence = r_out_seq;
    // slot read data sits in the ring, zero unless a reserve succeeded
    assign o_result_data     = r_out_rsv ? w_rd_word : '0;
    assign o_result_bytes    = r_out_rsv ? w_rd_len  : '0;

    // held messages always span oldest up to the send counter
    a_ring_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest + SEQ_W'(r_held)) == r_send)
        else $error("held window does not end at send counter");

    a_drain_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_held != '0))
        else $error("drain running with no held message");

    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("processed beat left no result");

    a_publish_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (t_func'(r_in_func) == FN_PUBLISH) && (w_status == ST_OK))
        |=> (r_send == $past(r_send) + SEQ_W'(1)))
        else $error("accepted publish did not advance send counter");

endmodule
`default_nettype wire
